// ----- rtl/core/bgc_pkg.sv -----
package bgc_pkg;

    // timestamp width, wraps modulo 2^TIME_BITS
    localparam int TIME_BITS = 48;

    // thresholds are kept in microseconds: 65535 ms * 1000 fits in 26 bits
    localparam int MS_BITS  = 16;
    localparam int THR_BITS = 26;
    localparam int US_PER_MS = 1000;

    localparam int CFG_IDX_BITS = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG     = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_SNAP     = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD     = CFG_IDX_BITS'(3);

    localparam logic [MS_BITS-1:0] DEBOUNCE_MS_RST = MS_BITS'(25);
    localparam logic [MS_BITS-1:0] LONG_MS_RST     = MS_BITS'(1000);
    localparam logic [MS_BITS-1:0] SNAP_MS_RST     = MS_BITS'(3000);
    localparam logic [MS_BITS-1:0] HOLD_MS_RST     = MS_BITS'(5000);

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_SHORT = 3'd1,
        EV_LONG  = 3'd2,
        EV_SNAP  = 3'd3,
        EV_HOLD  = 3'd4
    } bgc_event_t;

    typedef struct packed {
        logic [THR_BITS-1:0] debounce_us;
        logic [THR_BITS-1:0] long_us;
        logic [THR_BITS-1:0] snap_us;
        logic [THR_BITS-1:0] hold_us;
    } bgc_thr_t;

    function automatic logic [THR_BITS-1:0] ms_to_us(input logic [MS_BITS-1:0] ms);
        logic [THR_BITS-1:0] us;
        us = THR_BITS'(ms) * THR_BITS'(US_PER_MS);
        return us;
    endfunction

endpackage

// ----- rtl/core/bgc_cfg_regs.sv -----
module bgc_cfg_regs
    import bgc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [MS_BITS-1:0]      cfg_data,
    output bgc_thr_t                thr
);

    // ms -> us conversion done at write time, so compares need no divider
    bgc_thr_t thr_reg;
    bgc_thr_t thr_next;
    logic [THR_BITS-1:0] data_us;

    assign data_us = ms_to_us(cfg_data);

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE: thr_next.debounce_us = data_us;
                REG_LONG:     thr_next.long_us     = data_us;
                REG_SNAP:     thr_next.snap_us     = data_us;
                REG_HOLD:     thr_next.hold_us     = data_us;
                default:      thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.debounce_us <= ms_to_us(DEBOUNCE_MS_RST);
            thr_reg.long_us     <= ms_to_us(LONG_MS_RST);
            thr_reg.snap_us     <= ms_to_us(SNAP_MS_RST);
            thr_reg.hold_us     <= ms_to_us(HOLD_MS_RST);
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

// ----- rtl/core/bgc_classifier.sv -----
module bgc_classifier
    import bgc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 level,
    input  logic [TIME_BITS-1:0] now,
    input  bgc_thr_t             thr,
    output bgc_event_t           ev
);

    logic                 was_pressed_reg, was_pressed_next;
    logic                 hold_done_reg, hold_done_next;
    logic                 snap_done_reg, snap_done_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;

    logic                 down;
    logic [TIME_BITS-1:0] elapsed_us;
    logic                 ge_debounce, ge_long, ge_snap, ge_hold;

    assign down       = !level;
    assign elapsed_us = now - press_time_reg;

    // floor(us/1000) >= T  <=>  us >= T*1000
    assign ge_debounce = elapsed_us >= TIME_BITS'(thr.debounce_us);
    assign ge_long     = elapsed_us >= TIME_BITS'(thr.long_us);
    assign ge_snap     = elapsed_us >= TIME_BITS'(thr.snap_us);
    assign ge_hold     = elapsed_us >= TIME_BITS'(thr.hold_us);

    always_comb
    begin
        was_pressed_next = was_pressed_reg;
        hold_done_next   = hold_done_reg;
        snap_done_next   = snap_done_reg;
        press_time_next  = press_time_reg;
        ev               = EV_NONE;
        if (en)
        begin
            if (down && !was_pressed_reg)
            begin
                was_pressed_next = 1'b1;
                hold_done_next   = 1'b0;
                snap_done_next   = 1'b0;
                press_time_next  = now;
            end
            else if (down)
            begin
                if (!hold_done_reg && ge_hold)
                begin
                    hold_done_next = 1'b1;
                    ev             = EV_HOLD;
                end
                else if (!snap_done_reg && ge_snap)
                begin
                    snap_done_next = 1'b1;
                    ev             = EV_SNAP;
                end
            end
            else if (was_pressed_reg)
            begin
                was_pressed_next = 1'b0;
                if (hold_done_reg || snap_done_reg || !ge_debounce)
                    ev = EV_NONE;
                else if (ge_long)
                    ev = EV_LONG;
                else
                    ev = EV_SHORT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= 1'b0;
            hold_done_reg   <= 1'b0;
            snap_done_reg   <= 1'b0;
            press_time_reg  <= '0;
        end
        else
        begin
            was_pressed_reg <= was_pressed_next;
            hold_done_reg   <= hold_done_next;
            snap_done_reg   <= snap_done_next;
            press_time_reg  <= press_time_next;
        end
    end

    a_hold_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ev == EV_HOLD) |=> hold_done_reg)
        else $error("hold reported but flag not set");

    a_snap_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ev == EV_SNAP) |=> snap_done_reg)
        else $error("snap reported but flag not set");

    a_idle_release_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (en && level && !was_pressed_reg) |-> (ev == EV_NONE && was_pressed_next == 1'b0))
        else $error("release with no press pending gave an event");

endmodule

// ----- rtl/core/button_gesture_classifier_unit.sv -----
// Button gesture classifier: short / long / snap / hold press detection.
//
// Input channel (in_valid / in_stall): one poll sample per item, the raw
// active-low button_level and a free-running microsecond timestamp now_us.
// Output channel (out_valid / out_stall): exactly one event_res per sample,
// 0 none, 1 short, 2 long, 3 snap, 4 hold.
// Config port: cfg_we writes cfg_data (ms) into register cfg_index
// (0 debounce, 1 long, 2 snap, 3 hold); other indexes are ignored.
// Pipeline: input register, then the result register fed by the classifier.
// Throughput: one item per cycle while out_stall is low, set by the state
// update in the classifier.
// A stalled result holds in the result register while one more sample
// waits in the input register; in_stall rises only when both are full.
// Reset: press state and fired flags cleared, thresholds back to
// 25 / 1000 / 3000 / 5000 ms, both pipeline stages empty.
module button_gesture_classifier_unit
    import bgc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input samples
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    button_level,
    input  logic [TIME_BITS-1:0]    now_us,
    // results
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              event_res,
    // configuration
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [MS_BITS-1:0]      cfg_data
);

    bgc_thr_t   thr;
    bgc_event_t ev;

    // input stage
    logic                 s1_valid_reg;
    logic                 s1_level_reg;
    logic [TIME_BITS-1:0] s1_now_reg;

    // result stage
    logic                 out_valid_reg;
    bgc_event_t           event_reg;

    logic res_free;
    logic s1_move;
    logic in_take;

    assign res_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && res_free;
    assign in_stall = s1_valid_reg && !res_free;
    assign in_take  = in_valid && !in_stall;

    bgc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    // state only advances when the sample moves into the result register
    bgc_classifier u_cls (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s1_move),
        .level (s1_level_reg),
        .now   (s1_now_reg),
        .thr   (thr),
        .ev    (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (res_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_level_reg <= button_level;
            s1_now_reg   <= now_us;
        end
        if (s1_move)
            event_reg <= ev;
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a sample");

    a_blocked_sample_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !res_free) |=> (s1_valid_reg && $stable(s1_now_reg)))
        else $error("blocked sample lost");

endmodule

// ----- verif/bgc_event_checker.sv -----
module bgc_event_checker
    import bgc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    button_level,
    input  logic [TIME_BITS-1:0]    now_us,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [2:0]              event_res,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [MS_BITS-1:0]      cfg_data,
    output int                      pending,
    output int                      mismatch_count
);

    logic [MS_BITS-1:0]   min_press_ms;
    logic [MS_BITS-1:0]   long_ms;
    logic [MS_BITS-1:0]   snap_ms;
    logic [MS_BITS-1:0]   hold_ms;
    logic                 pressed;
    logic                 hold_seen;
    logic                 snap_seen;
    logic [TIME_BITS-1:0] press_stamp;
    bgc_event_t           expected_events[$];
    bgc_event_t           oldest;

    // whole ms since the press edge, difference taken modulo 2^TIME_BITS
    function automatic logic [TIME_BITS-1:0] held_ms(input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] diff_us;
        diff_us = now - press_stamp;
        return diff_us / TIME_BITS'(US_PER_MS);
    endfunction

    function automatic bgc_event_t classify_sample(input logic level,
                                                   input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] held;
        bgc_event_t           ev;
        ev   = EV_NONE;
        held = held_ms(now);
        if (!level && !pressed)
        begin
            pressed     = 1'b1;
            hold_seen   = 1'b0;
            snap_seen   = 1'b0;
            press_stamp = now;
        end
        else if (!level)
        begin
            if (!hold_seen && held >= hold_ms)
            begin
                hold_seen = 1'b1;
                ev        = EV_HOLD;
            end
            else if (!snap_seen && held >= snap_ms)
            begin
                snap_seen = 1'b1;
                ev        = EV_SNAP;
            end
        end
        else if (pressed)
        begin
            pressed = 1'b0;
            if (hold_seen || snap_seen)
                ev = EV_NONE;
            else if (held < min_press_ms)
                ev = EV_NONE;
            else if (held >= long_ms)
                ev = EV_LONG;
            else
                ev = EV_SHORT;
        end
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_press_ms   = DEBOUNCE_MS_RST;
            long_ms        = LONG_MS_RST;
            snap_ms        = SNAP_MS_RST;
            hold_ms        = HOLD_MS_RST;
            pressed        = 1'b0;
            hold_seen      = 1'b0;
            snap_seen      = 1'b0;
            press_stamp    = '0;
            expected_events.delete();
            pending        <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            // results lag behind the pipeline registers, so compare before queuing this edge's item
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none queued, actual event_res %0d",
                             $time, event_res);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    oldest = expected_events.pop_front();
                    if (event_res !== oldest)
                    begin
                        $display("%0t: event_res mismatch: expected %0d (%s), actual %0d",
                                 $time, oldest, oldest.name(), event_res);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE: min_press_ms = cfg_data;
                    REG_LONG:     long_ms      = cfg_data;
                    REG_SNAP:     snap_ms      = cfg_data;
                    REG_HOLD:     hold_ms      = cfg_data;
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_events.push_back(classify_sample(button_level, now_us));
            pending <= expected_events.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
module tb_top
    import bgc_pkg::*;
();

    // cycles with no item moving on either channel before the run is called hung
    localparam int QUIET_LIMIT    = 4000;
    // long receiver hold-off: well past the two-deep pipeline, so in_stall must rise
    localparam int HOLDOFF_CYCLES = 64;
    localparam int PHASE_ITEMS    = 155;
    // indexes outside the register file; writes there must be dropped
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LO = REG_HOLD + 1'b1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HI = '1;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    button_level;
    logic [TIME_BITS-1:0]    now_us;
    logic                    out_valid;
    logic                    out_stall;
    logic [2:0]              event_res;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [MS_BITS-1:0]      cfg_data;
    int                      pending;
    int                      mismatch_count;

    // stimulus-side copy of the thresholds, only used to aim press lengths
    logic [MS_BITS-1:0]      thr_ms [4];
    int                      send_pct  = 0;
    int                      stall_pct = 0;
    int                      items_sent = 0;
    int                      quiet_cycles = 0;
    bit                      holdoff_req = 1'b0;

    always #5 clk = ~clk;

    button_gesture_classifier_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button_level (button_level),
        .now_us       (now_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bgc_event_checker event_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_level   (button_level),
        .now_us         (now_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending        (pending),
        .mismatch_count (mismatch_count)
    );

    // Watchdog: any accepted item on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("button_gesture_classifier_unit test failed");
            $finish;
        end
    end

    // Result side. Random stall per cycle, or a long hold-off on request
    // while the sender keeps pushing, so the block backs up into in_stall.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_stamp();
        return TIME_BITS'({$urandom(), $urandom()});
    endfunction

    // One sample item. Idle cycles come first, so valid is only ever dropped
    // on a step where it is not raised again; once up, the payload holds
    // until the block takes it.
    task automatic send_sample(input logic level, input logic [TIME_BITS-1:0] stamp);
        @(negedge clk);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        button_level <= level;
        now_us       <= stamp;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Wait for every queued result, then let the pipeline settle.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [MS_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx <= REG_HOLD)
            thr_ms[idx] = val;
    endtask

    // A press/hold/release sequence with random content. Press length is
    // aimed within a ms of one of the thresholds most of the time; held
    // samples land either on a threshold or one us before it, or anywhere in the press.
    // Base time is random over 48 bits, so some presses wrap the counter.
    task automatic run_gesture();
        logic [TIME_BITS-1:0] t0;
        int unsigned          dur_us;
        int unsigned          probe_us;
        int unsigned          n_held;
        logic [MS_BITS-1:0]   th;
        t0 = rand_stamp();
        if ($urandom_range(99) < 30)
            send_sample(1'b1, rand_stamp());
        if ($urandom_range(4) == 0)
            dur_us = $urandom_range(66_000_000);
        else
        begin
            th     = thr_ms[$urandom_range(REG_HOLD)];
            dur_us = int'(th) * US_PER_MS + $urandom_range(2 * US_PER_MS - 1);
            dur_us = (dur_us >= US_PER_MS) ? dur_us - US_PER_MS : dur_us;
        end
        send_sample(1'b0, t0);
        n_held = $urandom_range(4);
        repeat (n_held)
        begin
            if ($urandom_range(1))
                probe_us = int'(thr_ms[$urandom_range(REG_HOLD)]) * US_PER_MS
                           - $urandom_range(1);
            else
                probe_us = $urandom_range(dur_us);
            send_sample(1'b0, t0 + probe_us);
        end
        send_sample(1'b1, t0 + dur_us);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input bit squeeze,
                             input logic [MS_BITS-1:0] deb, input logic [MS_BITS-1:0] lng,
                             input logic [MS_BITS-1:0] snp, input logic [MS_BITS-1:0] hld);
        int first;
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG, lng);
        write_reg(REG_SNAP, snp);
        write_reg(REG_HOLD, hld);
        send_pct  = s_pct;
        stall_pct = r_pct;
        first     = items_sent;
        if (squeeze)
            holdoff_req = 1'b1;
        while (items_sent - first < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 85)
                run_gesture();
            else
                send_sample(1'(($urandom_range(1))), rand_stamp());
            // second hold-off midway through a pressure phase
            if (squeeze && !holdoff_req && items_sent - first > PHASE_ITEMS / 2)
            begin
                holdoff_req = 1'b1;
                squeeze     = 1'b0;
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        button_level = 1'b1;
        now_us       = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_DEBOUNCE;
        cfg_data     = '0;
        thr_ms[REG_DEBOUNCE] = DEBOUNCE_MS_RST;
        thr_ms[REG_LONG]     = LONG_MS_RST;
        thr_ms[REG_SNAP]     = SNAP_MS_RST;
        thr_ms[REG_HOLD]     = HOLD_MS_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on reset thresholds (25 / 1000 / 3000 / 5000 ms).
        send_sample(1'b1, 48'd12_345);          // release with nothing pressed
        send_sample(1'b0, '0);                  // press at time zero
        send_sample(1'b1, 48'd24_999);          // 24 ms: bounce, nothing
        send_sample(1'b0, 48'd1_000_000);
        send_sample(1'b1, 48'd1_025_000);       // exactly debounce: short
        send_sample(1'b0, 48'd2_000_000);
        send_sample(1'b1, 48'd2_999_999);       // 999 ms: still short
        send_sample(1'b0, 48'd4_000_000);
        send_sample(1'b1, 48'd5_000_000);       // exactly long: long
        // held press walks through snap then hold, release then silent
        send_sample(1'b0, 48'd10_000_000);
        send_sample(1'b0, 48'd12_999_999);
        send_sample(1'b0, 48'd13_000_000);      // snap
        send_sample(1'b0, 48'd14_999_999);
        send_sample(1'b0, 48'd15_000_000);      // hold
        send_sample(1'b0, 48'd19_000_000);      // both fired, nothing more
        send_sample(1'b1, 48'd19_000_000);      // release after a fired rung
        // press at the top of the counter, release after wrap: 30 ms short
        send_sample(1'b0, '1);
        send_sample(1'b1, 48'd30_000);
        // timestamp runs backwards: reads as a huge press, hold then snap
        send_sample(1'b0, 48'd7_000_000);
        send_sample(1'b0, 48'd6_000_000);
        send_sample(1'b0, 48'd6_000_001);
        send_sample(1'b1, 48'd6_500_000);
        drain_results();

        // writes outside the register file must not disturb anything
        write_reg(REG_UNUSED_LO, 16'h0000);
        write_reg(REG_UNUSED_HI, 16'hFFFF);

        // all zero: hold fires on the first held sample after the edge, snap on the next
        run_phase(63, 0, 1'b0, '0, '0, '0, '0);
        // all max
        run_phase(0, 63, 1'b0, '1, '1, '1, '1);
        // snap above hold: hold comes first, snap can still follow
        run_phase(35, 35, 1'b0, 16'd10, 16'd200, 16'd900, 16'd400);
        // no idling, receiver holds off twice so the block fills up
        run_phase(0, 0, 1'b1, MS_BITS'($urandom_range(2000)), MS_BITS'($urandom_range(2000)),
                  MS_BITS'($urandom_range(2000)), MS_BITS'($urandom_range(2000)));
        write_reg(REG_UNUSED_LO, MS_BITS'($urandom()));
        run_phase(35, 35, 1'b0, MS_BITS'($urandom()), MS_BITS'($urandom()),
                  MS_BITS'($urandom()), MS_BITS'($urandom()));
        run_phase(63, 0, 1'b0, MS_BITS'($urandom_range(100)), MS_BITS'($urandom_range(3000)),
                  MS_BITS'($urandom_range(6000)), MS_BITS'($urandom_range(6000)));

        if (mismatch_count == 0)
            $display("button_gesture_classifier_unit test passed");
        else
            $display("button_gesture_classifier_unit test failed");
        $finish;
    end

endmodule
